FILE: hdl/ptc_pkg.sv
// Shared constants, codes and queue item type for the compact pointer codec.
// No dependencies.
`default_nettype none
package ptc_pkg;
  localparam int BUCKETS = 64;
  localparam int WAYS = 4;
  localparam int CAP = BUCKETS * WAYS;
  localparam int SET_W = $clog2(BUCKETS);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = 9;
  localparam logic [63:0] HASH_MUL = 64'h9E37_79B9_7F4A_7C15;

  localparam logic [1:0] REQ_ENC = 2'd0;
  localparam logic [1:0] REQ_DEC = 2'd1;
  localparam logic [1:0] REQ_PURGE = 2'd2;

  localparam logic [1:0] WSEL_32 = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;

  localparam logic [2:0] STAT_DIRECT = 3'd0;
  localparam logic [2:0] STAT_NULL = 3'd1;
  localparam logic [2:0] STAT_OVF = 3'd2;
  localparam logic [2:0] STAT_FULL = 3'd3;
  localparam logic [2:0] STAT_MISS = 3'd4;
  localparam logic [2:0] STAT_PURGED = 3'd5;

  typedef enum logic [1:0] {
    K_DIRECT = 2'd0,
    K_ENC_TBL = 2'd1,
    K_DEC_TBL = 2'd2,
    K_PURGE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [SET_W-1:0] set;
    logic [63:0] key;
    logic [63:0] tgt;
    logic [31:0] off;
    logic [2:0] status;
    logic [15:0] doc;
  } item_t;
endpackage
`default_nettype wire

FILE: hdl/ptc_req_if.sv
// Channel interfaces: request, response and configuration write.
// Depends on nothing.
`default_nettype none
interface ptc_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [1:0] width_sel;
  logic [2:0] align_shift;
  logic [63:0] base_addr;
  logic [63:0] target_addr;
  logic signed [31:0] offset_in;
  logic [63:0] slot_addr;
  logic [15:0] purge_doc;
  modport source (output valid, req_type, width_sel, align_shift, base_addr, target_addr,
                  offset_in, slot_addr, purge_doc, input ready);
  modport sink (input valid, req_type, width_sel, align_shift, base_addr, target_addr,
                offset_in, slot_addr, purge_doc, output ready);
endinterface

interface ptc_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] offset_out;
  logic [63:0] target_out;
  logic [2:0] status;
  logic [8:0] purge_count;
  modport source (output valid, offset_out, target_out, status, purge_count, input ready);
  modport sink (input valid, offset_out, target_out, status, purge_count, output ready);
endinterface

interface ptc_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/ptc_front.sv
// Front end: accepts requests, computes hash set, distance and direct results.
// Depends on ptc_pkg.
`default_nettype none
module ptc_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [1:0] width_sel,
  input  wire logic [2:0] align_shift,
  input  wire logic [63:0] base_addr,
  input  wire logic [63:0] target_addr,
  input  wire logic [31:0] offset_in,
  input  wire logic [63:0] slot_addr,
  input  wire logic [15:0] purge_doc,
  output logic push,
  input  wire logic full,
  output ptc_pkg::item_t item
);
  import ptc_pkg::*;

  logic s1_valid;
  logic [1:0] s1_req;
  logic [1:0] s1_wsel;
  logic [2:0] s1_sh;
  logic [63:0] s1_base;
  logic [63:0] s1_tgt;
  logic [31:0] s1_off;
  logic [63:0] s1_key;
  logic [15:0] s1_doc;
  logic [63:0] s1_d;
  logic [63:0] s1_plo;
  logic [SET_W-1:0] s1_px;

  logic drop, s1_go;
  logic [2:0] sh;
  logic [63:0] amask, scaled, dtgt;
  logic aligned, fits, notmin, direct;
  logic [31:0] sentinel, ext;

  assign drop = (s1_req != REQ_ENC) && (s1_req != REQ_DEC) && (s1_req != REQ_PURGE);
  assign s1_go = s1_valid && (drop || !full);
  assign push = s1_valid && !drop && !full;
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_req <= req_type;
      s1_wsel <= width_sel;
      s1_sh <= align_shift;
      s1_base <= base_addr;
      s1_tgt <= target_addr;
      s1_off <= offset_in;
      s1_key <= slot_addr;
      s1_doc <= purge_doc;
      s1_d <= target_addr - base_addr;
      s1_plo <= slot_addr[31:0] * HASH_MUL[31:0];
      s1_px <= SET_W'(slot_addr[32 +: SET_W] * HASH_MUL[SET_W-1:0])
             + SET_W'(slot_addr[SET_W-1:0] * HASH_MUL[32 +: SET_W]);
    end
  end

  always_comb begin
    sh = (s1_wsel == WSEL_32) ? 3'd0 : s1_sh;
    amask = (64'd1 << sh) - 64'd1;
    aligned = (s1_d & amask) == 64'd0;
    scaled = 64'($signed(s1_d) >>> sh);
    unique case (s1_wsel)
      WSEL_32: begin
        fits = (&scaled[63:31]) || !(|scaled[63:31]);
        notmin = scaled[31:0] != 32'h8000_0000;
        sentinel = 32'h8000_0000;
        ext = s1_off;
      end
      WSEL_16: begin
        fits = (&scaled[63:15]) || !(|scaled[63:15]);
        notmin = scaled[15:0] != 16'h8000;
        sentinel = 32'hFFFF_8000;
        ext = {{16{s1_off[15]}}, s1_off[15:0]};
      end
      default: begin
        fits = (&scaled[63:7]) || !(|scaled[63:7]);
        notmin = scaled[7:0] != 8'h80;
        sentinel = 32'hFFFF_FF80;
        ext = {{24{s1_off[7]}}, s1_off[7:0]};
      end
    endcase
    direct = aligned && fits && notmin;
    dtgt = s1_base + ({{32{ext[31]}}, ext} << sh);
  end

  always_comb begin
    item.kind = K_DIRECT;
    item.set = s1_plo[32 +: SET_W] + s1_px;
    item.key = s1_key;
    item.tgt = 64'd0;
    item.off = 32'd0;
    item.status = STAT_DIRECT;
    item.doc = s1_doc;
    priority if (s1_req == REQ_ENC) begin
      if (s1_tgt == 64'd0) begin
        item.status = STAT_NULL;
      end else if (direct) begin
        item.off = scaled[31:0];
      end else if (s1_key == 64'd0) begin
        item.status = STAT_FULL;
      end else begin
        item.kind = K_ENC_TBL;
        item.tgt = s1_tgt;
        item.off = sentinel;
      end
    end else if (s1_req == REQ_DEC) begin
      item.off = ext;
      if (ext == 32'd0) begin
        item.status = STAT_NULL;
      end else if (ext == sentinel) begin
        if (s1_key == 64'd0) begin
          item.status = STAT_MISS;
        end else begin
          item.kind = K_DEC_TBL;
        end
      end else begin
        item.tgt = dtgt;
      end
    end else begin
      item.status = STAT_PURGED;
      if (s1_doc != 16'd0) begin
        item.kind = K_PURGE;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/ptc_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on ptc_pkg.
`default_nettype none
module ptc_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire ptc_pkg::item_t push_item,
  output logic full,
  input  wire logic pop,
  output logic head_valid,
  output ptc_pkg::item_t head
);
  import ptc_pkg::*;

  item_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/ptc_back.sv
// Back end: overflow table memory, lookups, stores, purge sweep, result register.
// Depends on ptc_pkg.
`default_nettype none
module ptc_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [15:0] current_doc,
  input  wire logic head_valid,
  input  wire ptc_pkg::item_t head,
  output logic pop,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [31:0] offset_out,
  output logic [63:0] target_out,
  output logic [2:0] status,
  output logic [8:0] purge_count
);
  import ptc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TBL = 4'b0010,
    S_PRD = 4'b0100,
    S_PEV = 4'b1000
  } state_t;

  state_t state;
  item_t cur;
  logic [SET_W-1:0] row;
  logic [CNT_W-1:0] removed;

  logic [63:0] key_mem [BUCKETS][WAYS];
  logic [63:0] tgt_mem [BUCKETS][WAYS];
  logic [15:0] doc_mem [BUCKETS][WAYS];
  logic [WAYS-1:0] valid_q [BUCKETS];

  logic [63:0] rd_keys [WAYS];
  logic [63:0] rd_tgts [WAYS];
  logic [15:0] rd_docs [WAYS];
  logic [SET_W-1:0] rd_set;

  logic out_free;
  logic [WAYS-1:0] vrow, hit, match;
  logic hit_any, free_any;
  logic [WAY_W-1:0] hit_idx, free_idx;
  logic [CNT_W-1:0] removed_next;
  logic we;
  logic [WAY_W-1:0] we_way;

  assign out_free = !out_valid || out_ready;
  assign pop = (state == S_IDLE) && head_valid && out_free;
  assign rd_set = (state == S_IDLE) ? head.set : row;

  always_comb begin
    vrow = (state == S_PEV) ? valid_q[row] : valid_q[cur.set];
    hit_any = 1'b0;
    free_any = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    removed_next = removed;
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = vrow[w] && (rd_keys[w] == cur.key);
      match[w] = vrow[w] && (rd_docs[w] == cur.doc);
      removed_next = removed_next + CNT_W'(match[w]);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_any = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!vrow[w]) begin
        free_any = 1'b1;
        free_idx = WAY_W'(w);
      end
    end
    we = (state == S_TBL) && (cur.kind == K_ENC_TBL) && (hit_any || free_any);
    we_way = hit_any ? hit_idx : free_idx;
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < WAYS; w++) begin
      rd_keys[w] <= key_mem[rd_set][w];
      rd_tgts[w] <= tgt_mem[rd_set][w];
      rd_docs[w] <= doc_mem[rd_set][w];
    end
    if (we) begin
      key_mem[cur.set][we_way] <= cur.key;
      tgt_mem[cur.set][we_way] <= cur.tgt;
      doc_mem[cur.set][we_way] <= current_doc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (we && !hit_any) begin
        valid_q[cur.set][free_idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= head;
            unique case (head.kind)
              K_DIRECT: begin
                out_valid <= 1'b1;
                offset_out <= head.off;
                target_out <= head.tgt;
                status <= head.status;
                purge_count <= '0;
              end
              K_ENC_TBL, K_DEC_TBL: state <= S_TBL;
              K_PURGE: begin
                row <= '0;
                removed <= '0;
                state <= S_PRD;
              end
            endcase
          end
        end
        S_TBL: begin
          out_valid <= 1'b1;
          purge_count <= '0;
          offset_out <= cur.off;
          target_out <= 64'd0;
          if (cur.kind == K_ENC_TBL) begin
            status <= (hit_any || free_any) ? STAT_OVF : STAT_FULL;
            if (!(hit_any || free_any)) begin
              offset_out <= 32'd0;
            end
          end else begin
            status <= hit_any ? STAT_OVF : STAT_MISS;
            if (hit_any) begin
              target_out <= rd_tgts[hit_idx];
            end
          end
          state <= S_IDLE;
        end
        S_PRD: state <= S_PEV;
        S_PEV: begin
          valid_q[row] <= valid_q[row] & ~match;
          removed <= removed_next;
          if (row == SET_W'(BUCKETS - 1)) begin
            out_valid <= 1'b1;
            offset_out <= 32'd0;
            target_out <= 64'd0;
            status <= STAT_PURGED;
            purge_count <= removed_next;
            state <= S_IDLE;
          end else begin
            row <= row + SET_W'(1);
            state <= S_PRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/compact_pointer_codec_with_overflow.sv
// Top level of the compact pointer codec: config register, front, queue, back.
// Depends on ptc_pkg, the channel interfaces, ptc_front, ptc_queue, ptc_back.
//
// Usage: requests enter on req (encode, decode, purge); one response per
// encode, decode or purge leaves on rsp; an unused request type is consumed
// silently. cfg writes the 16-bit current_doc tag, always ready; write it
// only while the block is idle.
// Path: a direct result is registered in the front stage, the queue and
// the result register; a table lookup or store adds the set read and S_TBL,
// and a purge reads each of the 64 rows in S_PRD and evaluates it in S_PEV.
// Throughput: the back end retires one direct item per cycle while rsp
// accepts results; a table item holds it for a set read, then compare and
// write back, and a purge for the whole sweep. A two-entry queue decouples
// front and back. Reset (rst, synchronous) clears all valid bits of the table,
// the queue and current_doc. When rsp stalls, the result register holds, the back
// end stops, and the front keeps accepting until the queue fills.
`default_nettype none
module compact_pointer_codec_with_overflow (
  input wire logic clk,
  input wire logic rst,
  ptc_req_if.sink req,
  ptc_rsp_if.source rsp,
  ptc_cfg_if.sink cfg
);
  import ptc_pkg::*;

  logic [15:0] current_doc;
  logic push, full, pop, head_valid;
  item_t push_item, head;
  logic [31:0] off_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_doc <= 16'd0;
    end else if (cfg.valid) begin
      current_doc <= cfg.data;
    end
  end

  ptc_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(req.valid),
    .in_ready(req.ready),
    .req_type(req.req_type),
    .width_sel(req.width_sel),
    .align_shift(req.align_shift),
    .base_addr(req.base_addr),
    .target_addr(req.target_addr),
    .offset_in(req.offset_in),
    .slot_addr(req.slot_addr),
    .purge_doc(req.purge_doc),
    .push(push),
    .full(full),
    .item(push_item)
  );

  ptc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .full(full),
    .pop(pop),
    .head_valid(head_valid),
    .head(head)
  );

  ptc_back u_back (
    .clk(clk),
    .rst(rst),
    .current_doc(current_doc),
    .head_valid(head_valid),
    .head(head),
    .pop(pop),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .offset_out(off_q),
    .target_out(rsp.target_out),
    .status(rsp.status),
    .purge_count(rsp.purge_count)
  );

  assign rsp.offset_out = off_q;
endmodule
`default_nettype wire

FILE: bench/ptc_tb_pkg.sv
// Request and response item types for the pointer codec bench.
// Depends on ptc_pkg.
`default_nettype none
package ptc_tb_pkg;
  import ptc_pkg::*;

  typedef struct {
    logic [1:0] req_type;
    logic [1:0] width_sel;
    logic [2:0] align_shift;
    logic [63:0] base_addr;
    logic [63:0] target_addr;
    logic [31:0] offset_in;
    logic [63:0] slot_addr;
    logic [15:0] purge_doc;
  } codec_req_t;

  typedef struct {
    logic [31:0] offset_out;
    logic [63:0] target_out;
    logic [2:0] status;
    logic [8:0] purge_count;
  } codec_rsp_t;
endpackage
`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for compact_pointer_codec_with_overflow: directed and random
// encode/decode/purge traffic against a behavioral table model, with random stalls.
// Depends on ptc_pkg, ptc_tb_pkg, the channel interfaces and the RTL.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;
  import ptc_tb_pkg::*;

  logic clk;
  logic rst;
  ptc_req_if req ();
  ptc_rsp_if rsp ();
  ptc_cfg_if cfg ();

  compact_pointer_codec_with_overflow uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  codec_req_t pending_reqs[$];
  codec_rsp_t expected_rsps[$];
  logic [63:0] tbl_key[CAP];
  logic [63:0] tbl_tgt[CAP];
  logic [15:0] tbl_doc[CAP];
  logic tbl_vld[CAP];
  logic [15:0] doc_reg;
  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int transfers_out;
  logic [63:0] keys_used[$];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("** compact_pointer_codec_with_overflow: FAILED **");
    $finish;
  end

  function automatic int set_index(logic [63:0] key);
    logic [63:0] p;
    p = key * HASH_MUL;
    return int'(p[32 +: SET_W]);
  endfunction

  function automatic int lookup(logic [63:0] key);
    int b;
    b = set_index(key) * WAYS;
    for (int w = 0; w < WAYS; w++)
      if (tbl_vld[b+w] && tbl_key[b+w] == key) return b + w;
    return -1;
  endfunction

  function automatic bit store(logic [63:0] key, logic [63:0] tgt);
    int h;
    int b;
    if (key == 0) return 0;
    h = lookup(key);
    if (h >= 0) begin
      tbl_tgt[h] = tgt;
      tbl_doc[h] = doc_reg;
      return 1;
    end
    b = set_index(key) * WAYS;
    for (int w = 0; w < WAYS; w++)
      if (!tbl_vld[b+w]) begin
        tbl_vld[b+w] = 1;
        tbl_key[b+w] = key;
        tbl_tgt[b+w] = tgt;
        tbl_doc[b+w] = doc_reg;
        return 1;
      end
    return 0;
  endfunction

  // Returns 0 when the request type produces no response.
  function automatic bit predict_codec(codec_req_t r, output codec_rsp_t e);
    int bits;
    int sh;
    logic [63:0] wmask, half, d, scaled, o, ext;
    int h;
    e = '{default: '0};
    bits = (r.width_sel == WSEL_32) ? 32 : (r.width_sel == WSEL_16) ? 16 : 8;
    wmask = (64'd1 << bits) - 1;
    half = 64'd1 << (bits - 1);
    sh = (bits == 32) ? 0 : r.align_shift;
    if (r.req_type == REQ_ENC) begin
      if (r.target_addr == 0) e.status = STAT_NULL;
      else begin
        d = r.target_addr - r.base_addr;
        scaled = $signed(d) >>> sh;
        if ((d & ((64'd1 << sh) - 1)) == 0 && scaled + half - 1 <= wmask - 1) begin
          e.offset_out = scaled[31:0];
          e.status = STAT_DIRECT;
        end else if (store(r.slot_addr, r.target_addr)) begin
          ext = ~(half - 1);
          e.offset_out = ext[31:0];
          e.status = STAT_OVF;
        end else e.status = STAT_FULL;
      end
      return 1;
    end
    if (r.req_type == REQ_DEC) begin
      o = {32'd0, r.offset_in} & wmask;
      ext = (o & half) ? (o | ~wmask) : o;
      e.offset_out = ext[31:0];
      if (o == 0) e.status = STAT_NULL;
      else if (o == half) begin
        h = (r.slot_addr == 0) ? -1 : lookup(r.slot_addr);
        if (h >= 0) begin
          e.target_out = tbl_tgt[h];
          e.status = STAT_OVF;
        end else e.status = STAT_MISS;
      end else begin
        e.target_out = r.base_addr + (ext << sh);
        e.status = STAT_DIRECT;
      end
      return 1;
    end
    if (r.req_type == REQ_PURGE) begin
      if (r.purge_doc != 0)
        for (int i = 0; i < CAP; i++)
          if (tbl_vld[i] && tbl_doc[i] == r.purge_doc) begin
            tbl_vld[i] = 0;
            e.purge_count++;
          end
      e.status = STAT_PURGED;
      return 1;
    end
    return 0;
  endfunction

  // Driver
  always @(posedge clk) begin
    codec_req_t r;
    codec_rsp_t e;
    if (rst) req.valid <= 0;
    else begin
      if (req.valid && req.ready) begin
        r.req_type = req.req_type; r.width_sel = req.width_sel;
        r.align_shift = req.align_shift; r.base_addr = req.base_addr;
        r.target_addr = req.target_addr; r.offset_in = req.offset_in;
        r.slot_addr = req.slot_addr; r.purge_doc = req.purge_doc;
        if (predict_codec(r, e)) expected_rsps.push_back(e);
      end
      if ((!req.valid || req.ready)) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          req.valid <= 1;
          req.req_type <= r.req_type; req.width_sel <= r.width_sel;
          req.align_shift <= r.align_shift; req.base_addr <= r.base_addr;
          req.target_addr <= r.target_addr; req.offset_in <= r.offset_in;
          req.slot_addr <= r.slot_addr; req.purge_doc <= r.purge_doc;
        end else req.valid <= 0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    codec_rsp_t e;
    if (rst) rsp.ready <= 0;
    else begin
      if (rsp.valid && rsp.ready) begin
        transfers_out++;
        if (expected_rsps.size() == 0) begin
          $error("unexpected response transfer");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.offset_out !== e.offset_out) begin
            $error("offset_out exp %h got %h", e.offset_out, rsp.offset_out); errors++;
          end
          if (rsp.target_out !== e.target_out) begin
            $error("target_out exp %h got %h", e.target_out, rsp.target_out); errors++;
          end
          if (rsp.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, rsp.status); errors++;
          end
          if (rsp.purge_count !== e.purge_count) begin
            $error("purge_count exp %0d got %0d", e.purge_count, rsp.purge_count);
            errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic codec_req_t mk(logic [1:0] rt, logic [1:0] ws, logic [2:0] sh,
      logic [63:0] b, logic [63:0] t, logic [31:0] o, logic [63:0] f, logic [15:0] pd);
    codec_req_t r;
    r.req_type = rt; r.width_sel = ws; r.align_shift = sh; r.base_addr = b;
    r.target_addr = t; r.offset_in = o; r.slot_addr = f; r.purge_doc = pd;
    return r;
  endfunction

  function automatic logic [63:0] pick_key();
    if (keys_used.size() > 0 && $urandom_range(2) != 0)
      return keys_used[$urandom_range(keys_used.size() - 1)];
    if ($urandom_range(30) == 0) return 0;
    keys_used.push_back(rand64());
    return keys_used[$];
  endfunction

  function automatic codec_req_t rand_req();
    codec_req_t r;
    logic [63:0] b;
    int k;
    int s;
    int bits;
    logic [63:0] d;
    b = rand64();
    k = $urandom_range(99);
    r = mk(REQ_ENC, 2'($urandom_range(3)), 3'($urandom_range(7)), b, 64'd0, $urandom,
           pick_key(), 16'($urandom_range(4)));
    bits = (r.width_sel == WSEL_32) ? 32 : (r.width_sel == WSEL_16) ? 16 : 8;
    s = (bits == 32) ? 0 : r.align_shift;
    if (k < 45) begin
      case ($urandom_range(4))
        0: d = rand64();
        1: d = $signed(64'(-(64'd1 << (bits - 1)))) <<< s;
        2: d = 64'(((64'd1 << (bits - 1)) - 1)) << s;
        3: d = 64'(($urandom_range(7) - 3)) + (64'($signed(32'($urandom))) >>> (33 - bits) << s);
        default: d = 64'($signed(32'($urandom))) >>> (32 - bits) << s;
      endcase
      r.target_addr = ($urandom_range(20) == 0) ? 0 : b + d;
    end else if (k < 92) begin
      r.req_type = REQ_DEC;
      case ($urandom_range(3))
        0: r.offset_in = 32'h8000_0000 >> (32 - bits);
        1: r.offset_in = 32'hFFFF_FF00 | (32'h8000_0000 >> (32 - bits));
        2: r.offset_in = 0;
        default: r.offset_in = $urandom;
      endcase
    end else if (k < 98) r.req_type = REQ_PURGE;
    else r.req_type = 2'd3;
    return r;
  endfunction

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0) @(posedge clk);
    repeat (2 * BUCKETS + 20) @(posedge clk);
  endtask

  task automatic write_doc(logic [15:0] v);
    @(posedge clk);
    cfg.valid <= 1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    doc_reg = v;
    cfg.valid <= 0;
  endtask

  initial begin
    int phase_items;
    for (int i = 0; i < CAP; i++) tbl_vld[i] = 0;
    doc_reg = 0; errors = 0; transfers_out = 0;
    send_idle_pct = 6; recv_idle_pct = 52;
    rst = 1;
    req.valid = 0; req.req_type = 0; req.width_sel = 0; req.align_shift = 0;
    req.base_addr = 0; req.target_addr = 0; req.offset_in = 0; req.slot_addr = 0;
    req.purge_doc = 0; rsp.ready = 0; cfg.valid = 0; cfg.data = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // directed
    pending_reqs.push_back(mk(REQ_ENC, WSEL_32, 0, 64'h1000, 0, 0, 64'h10, 0));
    pending_reqs.push_back(mk(REQ_ENC, WSEL_32, 0, 64'h1000, 64'h1000, 0, 64'h10, 0));
    pending_reqs.push_back(mk(REQ_ENC, WSEL_32, 0, 64'h8000_0000, 64'h1, 0, 64'h10, 0));
    pending_reqs.push_back(mk(REQ_ENC, WSEL_32, 0, 0, 64'h7FFF_FFFF, 0, 64'h20, 0));
    pending_reqs.push_back(mk(REQ_ENC, WSEL_32, 0, 64'h8000_0001, 64'h1, 0, 64'h20, 0));
    pending_reqs.push_back(mk(REQ_ENC, WSEL_16, 6, 0, 64'h40, 0, 64'h30, 0));
    pending_reqs.push_back(mk(REQ_ENC, WSEL_16, 6, 0, 64'h41, 0, 64'h30, 0));
    pending_reqs.push_back(mk(REQ_ENC, 2'd3, 7, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_ENC, 2'd2, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7F, 0, 64'h40, 0));
    pending_reqs.push_back(mk(REQ_DEC, WSEL_32, 0, 0, 0, 32'h8000_0000, 64'h10, 0));
    pending_reqs.push_back(mk(REQ_DEC, WSEL_16, 6, 0, 0, 32'hFFFF_8000, 64'h30, 0));
    pending_reqs.push_back(mk(REQ_DEC, 2'd2, 0, 0, 0, 32'h80, 64'h99, 0));
    pending_reqs.push_back(mk(REQ_DEC, 2'd3, 0, 0, 0, 32'h80, 0, 0));
    pending_reqs.push_back(mk(REQ_DEC, WSEL_32, 7, 64'hFFFF_FFFF_FFFF_FFFF, 0,
                              32'h7FFF_FFFF, 0, 0));
    pending_reqs.push_back(mk(REQ_DEC, 2'd2, 5, 0, 0, 32'hFFFF_FF00, 0, 0));
    pending_reqs.push_back(mk(2'd3, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_PURGE, 0, 0, 0, 0, 0, 0, 0));
    wait_drain();
    write_doc(16'hFFFF);
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(mk(REQ_ENC, WSEL_32, 0, 0, 64'hF000_0000_0000_0000 + i, 0,
                                64'h5 + 64'(i) * 64'h1_0000_0000, 0));
    pending_reqs.push_back(mk(REQ_PURGE, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    pending_reqs.push_back(mk(REQ_PURGE, 0, 0, 0, 0, 0, 0, 0));
    wait_drain();
    // random phases across idle patterns and doc tags
    for (int p = 0; p < 6; p++) begin
      write_doc((p == 5) ? 16'h0000 : 16'($urandom_range(1, 4)));
      if (p == 2) begin send_idle_pct = 52; recv_idle_pct = 6; end
      if (p == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      phase_items = 75;
      for (int i = 0; i < phase_items; i++) pending_reqs.push_back(rand_req());
      wait_drain();
    end
    $display("Covered %0d responses over encode/decode/purge, all widths and shifts,",
             transfers_out);
    $display("overflow store, update, full sets, misses and several doc tags.");
    if (errors == 0) $display("** compact_pointer_codec_with_overflow: PASSED **");
    else $display("** compact_pointer_codec_with_overflow: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
hdl/ptc_pkg.sv
hdl/ptc_req_if.sv
hdl/ptc_front.sv
hdl/ptc_queue.sv
hdl/ptc_back.sv
hdl/compact_pointer_codec_with_overflow.sv
bench/ptc_tb_pkg.sv
bench/testbench.sv
